// ----- sv/fifo_handle_allocator_defines.svh -----
// ----------------------------------------------------------------------------
// fifo_handle_allocator_defines.svh
// Assertion macros for the handle allocator top-level checks.
// ----------------------------------------------------------------------------
`ifndef FIFO_HANDLE_ALLOCATOR_DEFINES_SVH
`define FIFO_HANDLE_ALLOCATOR_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Property checked at every clock edge outside reset.
`define FHA_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("fifo_handle_allocator: assertion failed");

// Condition that must never be seen outside reset.
`define FHA_ASSERT_NEVER(label, cond) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("fifo_handle_allocator: forbidden condition seen");

`else

`define FHA_ASSERT(label, prop)
`define FHA_ASSERT_NEVER(label, cond)

`endif

`endif

// ----- sv/fha_pkg.sv -----
// ----------------------------------------------------------------------------
// fha_pkg
// Shared types, widths and codes for the handle allocator.
// ----------------------------------------------------------------------------
package fha_pkg;

  localparam int PoolSize = 256;
  localparam int PtrW     = $clog2(PoolSize);      // queue index / handle bits
  localparam int CountW   = $clog2(PoolSize + 1);  // holds 0 .. PoolSize
  localparam int HandleW  = 8;
  localparam int FuncW    = 2;
  localparam int StatusW  = 2;

  // request codes
  localparam logic [FuncW-1:0] FUNC_ALLOC = 2'd0;
  localparam logic [FuncW-1:0] FUNC_TRY   = 2'd1;
  localparam logic [FuncW-1:0] FUNC_FREE  = 2'd2;

  // result status codes
  localparam logic [StatusW-1:0] STAT_OK        = 2'd0;
  localparam logic [StatusW-1:0] STAT_NONE_FREE = 2'd1;
  localparam logic [StatusW-1:0] STAT_NOT_ALLOC = 2'd2;
  localparam logic [StatusW-1:0] STAT_EXHAUSTED = 2'd3;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_READ,
    S_EXEC
  } fha_state_t;

  // controller -> datapath
  typedef struct packed {
    logic clear;   // zero one bitmap entry
    logic latch;   // capture the accepted request
    logic exec;    // apply request, load result register
  } fha_cmd_t;

  // datapath -> controller / checks
  typedef struct packed {
    logic              clear_done; // last bitmap entry being zeroed
    logic              out_busy;   // result register full and stalled
    logic [CountW-1:0] count;      // queued free handles
  } fha_stat_t;

endpackage

// ----- sv/fha_ram.sv -----
// ----------------------------------------------------------------------------
// fha_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module fha_ram #(
  parameter int Width = 8,
  parameter int Depth = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- sv/fha_dp.sv -----
// ----------------------------------------------------------------------------
// fha_dp
// Datapath: request register, free queue, allocated bitmap, fresh counter
// and result register.
// ----------------------------------------------------------------------------
module fha_dp
  import fha_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  fha_cmd_t           cmd,
  output fha_stat_t          stat,
  input  logic [15:0]        s_tdata,
  output logic               m_tvalid,
  input  logic               m_tready,
  output logic [15:0]        m_tdata
);

  logic [FuncW-1:0]   req_func;
  logic [HandleW-1:0] req_handle;

  logic [PtrW-1:0]    head, head_next;
  logic [PtrW-1:0]    tail, tail_next;
  logic [CountW-1:0]  count;
  logic [CountW-1:0]  fresh;
  logic [PtrW-1:0]    clr_addr;

  logic [PtrW-1:0]    q_rdata;
  logic               map_bit;
  logic               map_we;
  logic [PtrW-1:0]    map_waddr;
  logic               map_wdata;

  logic               have_free, fresh_left, in_range;
  logic [PtrW-1:0]    map_idx;
  logic               pop, push, fresh_take, grant;
  logic [PtrW-1:0]    grant_h;
  logic [StatusW-1:0] res_status;
  logic [HandleW-1:0] res_handle;
  logic [HandleW-1:0] out_handle;
  logic [StatusW-1:0] out_status;

  // request capture
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      req_func   <= s_tdata[FuncW-1:0];
      req_handle <= s_tdata[FuncW +: HandleW];
    end
  end

  // free queue storage; read port always looks at the head
  fha_ram #(
    .Width (PtrW),
    .Depth (PoolSize)
  ) u_queue (
    .clk   (clk),
    .we    (cmd.exec && push),
    .waddr (tail),
    .wdata (map_idx),
    .raddr (head),
    .rdata (q_rdata)
  );

  // allocated bitmap; read at the request's handle, zeroed after reset
  fha_ram #(
    .Width (1),
    .Depth (PoolSize)
  ) u_map (
    .clk   (clk),
    .we    (map_we),
    .waddr (map_waddr),
    .wdata (map_wdata),
    .raddr (map_idx),
    .rdata (map_bit)
  );

  assign map_we    = cmd.clear || (cmd.exec && (push || grant));
  assign map_waddr = cmd.clear ? clr_addr : (push ? map_idx : grant_h);
  assign map_wdata = !cmd.clear && grant;

  // clearing pass address
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clear) begin
      clr_addr <= clr_addr + 1'b1;
    end
  end

  assign have_free  = (count != '0);
  assign fresh_left = (fresh < CountW'(PoolSize));
  assign in_range   = (32'(req_handle) < PoolSize);
  assign map_idx    = req_handle[PtrW-1:0];

  assign head_next = (head == PtrW'(PoolSize - 1)) ? '0 : head + 1'b1;
  assign tail_next = (tail == PtrW'(PoolSize - 1)) ? '0 : tail + 1'b1;

  always_comb begin
    pop        = 1'b0;
    push       = 1'b0;
    fresh_take = 1'b0;
    grant      = 1'b0;
    grant_h    = '0;
    res_status = STAT_OK;
    case (req_func)
      FUNC_ALLOC: begin
        if (have_free) begin
          pop     = 1'b1;
          grant   = 1'b1;
          grant_h = q_rdata;
        end else if (fresh_left) begin
          fresh_take = 1'b1;
          grant      = 1'b1;
          grant_h    = fresh[PtrW-1:0];
        end else begin
          res_status = STAT_EXHAUSTED;
        end
      end
      FUNC_TRY: begin
        if (have_free) begin
          pop     = 1'b1;
          grant   = 1'b1;
          grant_h = q_rdata;
        end else begin
          res_status = STAT_NONE_FREE;
        end
      end
      FUNC_FREE: begin
        if (!in_range || !map_bit || count >= CountW'(PoolSize)) begin
          res_status = STAT_NOT_ALLOC;
        end else begin
          push = 1'b1;
        end
      end
      default: begin
        res_status = STAT_OK;
      end
    endcase
    res_handle = grant ? HandleW'(grant_h) : '0;
  end

  // queue pointers and fresh counter
  always_ff @(posedge clk) begin
    if (rst) begin
      head      <= '0;
      tail      <= '0;
      count     <= '0;
      fresh     <= '0;
    end else if (cmd.exec) begin
      if (pop) begin
        head  <= head_next;
        count <= count - 1'b1;
      end
      if (push) begin
        tail  <= tail_next;
        count <= count + 1'b1;
      end
      if (fresh_take) begin
        fresh <= fresh + 1'b1;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.exec) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      out_handle <= res_handle;
      out_status <= res_status;
    end
  end

  assign m_tdata = {6'b0, out_status, out_handle};

  assign stat.clear_done = (clr_addr == PtrW'(PoolSize - 1));
  assign stat.out_busy   = m_tvalid && !m_tready;
  assign stat.count      = count;

endmodule

// ----- sv/fha_ctrl.sv -----
// ----------------------------------------------------------------------------
// fha_ctrl
// Controller: bitmap clearing after reset, then accept, RAM read and
// execute for one item.
// ----------------------------------------------------------------------------
module fha_ctrl
  import fha_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      s_tvalid,
  output logic      s_tready,
  input  fha_stat_t stat,
  output fha_cmd_t  cmd
);

  fha_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: if (stat.clear_done) state_next = S_IDLE;
      S_IDLE: if (s_tvalid) state_next = S_READ;
      S_READ: state_next = S_EXEC;
      S_EXEC: if (!stat.out_busy) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    s_tready  = 1'b0;
    cmd.clear = 1'b0;
    cmd.latch = 1'b0;
    cmd.exec  = 1'b0;
    unique case (state)
      S_CLEAR: begin
        cmd.clear = 1'b1;
      end
      S_IDLE: begin
        s_tready  = 1'b1;
        cmd.latch = s_tvalid;
      end
      S_READ: begin
        s_tready = 1'b0;
      end
      S_EXEC: begin
        cmd.exec = !stat.out_busy;
      end
      default: begin
        s_tready = 1'b0;
      end
    endcase
  end

endmodule

// ----- sv/fifo_handle_allocator.sv -----
// ----------------------------------------------------------------------------
// fifo_handle_allocator
// Handle allocator with a FIFO of freed handles and an allocated bitmap.
// ----------------------------------------------------------------------------
// Each item is a request (allocate, try-allocate or deallocate) and gives
// exactly one result item: a handle and a status. An item passes through the
// accept, the registered reads of the free-queue head and of the request's
// allocated bit out of their RAMs, and the execute cycle that updates the
// queue, the bitmap and the fresh-handle counter and loads the result
// register. The execute cycle waits while the previous result is still held
// by the downstream side, so a stalled output holds the item back. The next
// item is taken as soon as the controller is back in idle, even with a
// result still waiting in the output register. The allocated bitmap is a
// RAM: after reset a clearing pass zeroes all 256 of its entries, one per
// handle, with s_tready held low. The free-queue RAM needs no clearing
// since only written entries are ever read.
// ----------------------------------------------------------------------------
`include "fifo_handle_allocator_defines.svh"

module fifo_handle_allocator
  import fha_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // request items
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [1:0] func, [9:2] handle, [15:10] zero
  // result items
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata    // [7:0] result_handle, [9:8] status, [15:10] zero
);

  fha_cmd_t  cmd;
  fha_stat_t stat;

  // sequencing: bitmap clear / idle / RAM read / execute
  fha_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // all allocator state and the result register
  fha_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .stat     (stat),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  // one item in flight: no accept in the cycle after an accept
  `FHA_ASSERT(a_one_in_flight, (s_tvalid && s_tready) |=> !s_tready)

  // a refused or failed request never carries a handle
  `FHA_ASSERT(a_fail_no_handle,
              (m_tvalid && m_tdata[9:8] != STAT_OK) |-> (m_tdata[7:0] == '0))

  // the free queue never holds more than the pool
  `FHA_ASSERT_NEVER(a_count_range, stat.count > CountW'(PoolSize))

  // a result is only loaded when the output register can take it
  `FHA_ASSERT_NEVER(a_no_overwrite, cmd.exec && stat.out_busy)

endmodule
